>>> src/cctc_pkg.sv
// shared types and constants of the cycle count to time converter
package cctc_pkg;

	localparam int CYC_W  = 32;
	localparam int MHZ_W  = 10;
	localparam int TOT_W  = 64;
	localparam int SEC_W  = 45;
	localparam int FRAC_W = 10;
	localparam int TICK_W = 55;
	localparam int CNT_W  = $clog2(TOT_W);

	localparam logic [MHZ_W-1:0]  MHZ_RESET = 10'd170;
	localparam logic [FRAC_W:0]   DEC_DIV   = 11'd1000;
	localparam logic [CNT_W-1:0]  LAST_STEP = CNT_W'(TOT_W - 1);

	typedef struct packed {
		logic [CYC_W-1:0] cycle_count;
	} cctc_in_t;

	typedef struct packed {
		logic [TOT_W-1:0]  total_cycles;
		logic [SEC_W-1:0]  seconds;
		logic [FRAC_W-1:0] milliseconds;
		logic [FRAC_W-1:0] microseconds;
		logic [TICK_W-1:0] ms_tick;
		logic [TOT_W-1:0]  total_us;
	} cctc_out_t;

	typedef struct packed {
		logic load;
		logic step;
		logic publish;
	} cctc_cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FIN
	} cctc_state_t;

endpackage

>>> src/cctc_ifs.sv
// valid/ready channel interfaces for input and result words
interface cctc_in_if;
	logic               valid;
	logic               ready;
	cctc_pkg::cctc_in_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface cctc_out_if;
	logic                valid;
	logic                ready;
	cctc_pkg::cctc_out_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> src/cycle_count_to_time_converter.sv
// top level: cycle counter wrap extension and time split
// Takes 32-bit snapshots of a free-running cycle counter and returns, per
// snapshot, one word with the wrap-extended 64-bit cycle total and the time
// it stands for at the clock set in cpu_mhz (cycles per microsecond; a value
// of 0 counts as 1): total microseconds, whole seconds, milliseconds and
// microseconds within them, and a millisecond tick. A snapshot below the
// previous one counts as one wrap; after reset the previous snapshot is 0.
// Timing: one word is in work at a time. After a word is taken it goes
// through a bit-serial long division of the total by cpu_mhz; the two
// divides by 1000 ride along on the same quotient bits in the same cycles.
// When the division is done, the result word is published once the result
// slot is free or being emptied; only then is a new word taken. The result
// sits in an output register, so the next word is accepted while the last
// result still waits to be taken.
// cpu_mhz is written with cfg_we/cfg_wdata and must only change while no
// word is in work; it resets to 170.
module cycle_count_to_time_converter (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [cctc_pkg::MHZ_W-1:0]  cfg_wdata,
	cctc_in_if.sink                     sample,
	cctc_out_if.source                  stamp
);

	// command bundle from controller to datapath
	cctc_pkg::cctc_cmd_t cmd;

	// controller: idle / divide / hand-off sequencing and result valid
	cctc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample.valid),
		.in_ready  (sample.ready),
		.out_ready (stamp.ready),
		.out_valid (stamp.valid),
		.cmd       (cmd)
	);

	// datapath: wrap state, clock register, divider chain, result register
	cctc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.in_data   (sample.data),
		.out_data  (stamp.data)
	);

endmodule

>>> src/cctc_ctrl.sv
// controller: sequences load, the 64 divide steps and the result hand-off
module cctc_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  out_ready,
	output logic                  out_valid,
	output cctc_pkg::cctc_cmd_t   cmd
);

	cctc_pkg::cctc_state_t        state_q, state_d;
	logic [cctc_pkg::CNT_W-1:0]   cnt_q, cnt_d;
	logic                         ov_q, ov_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cctc_pkg::ST_IDLE;
			cnt_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			ov_q    <= ov_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		cmd.load    = 1'b0;
		cmd.step    = 1'b0;
		cmd.publish = 1'b0;
		in_ready    = 1'b0;
		unique case (state_q)
			cctc_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					cnt_d    = '0;
					state_d  = cctc_pkg::ST_RUN;
				end
			end
			cctc_pkg::ST_RUN: begin
				cmd.step = 1'b1;
				cnt_d    = cnt_q + 1'b1;
				if (cnt_q == cctc_pkg::LAST_STEP) begin
					state_d = cctc_pkg::ST_FIN;
				end
			end
			cctc_pkg::ST_FIN: begin
				// output slot free or being emptied this cycle
				if (!ov_q || out_ready) begin
					cmd.publish = 1'b1;
					state_d     = cctc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = cctc_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		if (cmd.publish) begin
			ov_d = 1'b1;
		end else if (out_ready) begin
			ov_d = 1'b0;
		end else begin
			ov_d = ov_q;
		end
	end

	assign out_valid = ov_q;

endmodule

>>> src/cctc_dp.sv
// datapath: wrap extension, bit-serial divide by clock and cascaded divides by 1000
module cctc_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [cctc_pkg::MHZ_W-1:0]    cfg_wdata,
	input  cctc_pkg::cctc_cmd_t           cmd,
	input  cctc_pkg::cctc_in_t            in_data,
	output cctc_pkg::cctc_out_t           out_data
);

	logic [cctc_pkg::MHZ_W-1:0]  mhz_q;
	logic [cctc_pkg::CYC_W-1:0]  prev_q;
	logic [cctc_pkg::CYC_W-1:0]  wrap_q;
	logic [cctc_pkg::CYC_W-1:0]  wrap_next;
	logic [cctc_pkg::TOT_W-1:0]  tot_q;
	logic [cctc_pkg::TOT_W-1:0]  div_q;
	logic [cctc_pkg::FRAC_W-1:0] ra_q, rb_q, rc_q;
	logic [cctc_pkg::TICK_W-1:0] qb_q;
	logic [cctc_pkg::SEC_W-1:0]  qc_q;
	cctc_pkg::cctc_out_t         out_q;

	logic [cctc_pkg::MHZ_W-1:0]  f;
	logic [cctc_pkg::MHZ_W:0]    ta, tb, tc, na, nb, nc;
	logic                        ga, gb, gc;

	// zero clock setting divides by one
	assign f = (mhz_q == '0) ? cctc_pkg::MHZ_W'(1) : mhz_q;

	assign wrap_next = (in_data.cycle_count < prev_q) ? wrap_q + 1'b1 : wrap_q;

	// stage a: total / f, one quotient bit per step
	always_comb begin
		ta = {ra_q, div_q[cctc_pkg::TOT_W-1]};
		ga = (ta >= {1'b0, f});
		na = ga ? ta - {1'b0, f} : ta;
		// stage b: quotient bits of a divided by 1000
		tb = {rb_q, ga};
		gb = (tb >= cctc_pkg::DEC_DIV);
		nb = gb ? tb - cctc_pkg::DEC_DIV : tb;
		// stage c: quotient bits of b divided by 1000
		tc = {rc_q, gb};
		gc = (tc >= cctc_pkg::DEC_DIV);
		nc = gc ? tc - cctc_pkg::DEC_DIV : tc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mhz_q  <= cctc_pkg::MHZ_RESET;
			prev_q <= '0;
			wrap_q <= '0;
		end else begin
			if (cfg_we) begin
				mhz_q <= cfg_wdata;
			end
			if (cmd.load) begin
				prev_q <= in_data.cycle_count;
				wrap_q <= wrap_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			tot_q <= {wrap_next, in_data.cycle_count};
			div_q <= {wrap_next, in_data.cycle_count};
			ra_q  <= '0;
			rb_q  <= '0;
			rc_q  <= '0;
			qb_q  <= '0;
			qc_q  <= '0;
		end else if (cmd.step) begin
			div_q <= {div_q[cctc_pkg::TOT_W-2:0], ga};
			ra_q  <= na[cctc_pkg::FRAC_W-1:0];
			rb_q  <= nb[cctc_pkg::FRAC_W-1:0];
			rc_q  <= nc[cctc_pkg::FRAC_W-1:0];
			qb_q  <= {qb_q[cctc_pkg::TICK_W-2:0], gb};
			qc_q  <= {qc_q[cctc_pkg::SEC_W-2:0], gc};
		end
		if (cmd.publish) begin
			out_q.total_cycles <= tot_q;
			out_q.seconds      <= qc_q;
			out_q.milliseconds <= rc_q;
			out_q.microseconds <= rb_q;
			out_q.ms_tick      <= qb_q;
			out_q.total_us     <= div_q;
		end
	end

	assign out_data = out_q;

endmodule

>>> src/cctc_chk.sv
// port-level checker for the converter, bound to the top level
module cctc_chk (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input cctc_pkg::cctc_out_t  out_data
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result word changed while stalled");

	// one word in work at a time
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a word is in work");

	// a result never shows up the cycle after an input is taken
	a_no_instant: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_valid && in_ready))
		else $error("result appeared too early");

	// fractional fields stay below 1000
	a_frac_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ({1'b0, out_data.milliseconds} < cctc_pkg::DEC_DIV) &&
			({1'b0, out_data.microseconds} < cctc_pkg::DEC_DIV))
		else $error("millisecond or microsecond field out of range");

endmodule

bind cycle_count_to_time_converter cctc_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (sample.valid),
	.in_ready  (sample.ready),
	.out_valid (stamp.valid),
	.out_ready (stamp.ready),
	.out_data  (stamp.data)
);

>>> dv/cycle_count_to_time_converter_tb.sv
// self-checking testbench of the cycle count to time converter
module cycle_count_to_time_converter_tb;

	logic                        clk = 1'b0;
	logic                        arst_n;
	logic                        cfg_we;
	logic [cctc_pkg::MHZ_W-1:0]  cfg_wdata;

	cctc_in_if  sample_ch ();
	cctc_out_if stamp_ch ();

	cycle_count_to_time_converter DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.sample    (sample_ch),
		.stamp     (stamp_ch)
	);

	// own copy of the block state, advanced on every accepted snapshot
	logic [cctc_pkg::CYC_W-1:0]  snap_prev;
	logic [31:0]                 wrap_total;
	logic [cctc_pkg::MHZ_W-1:0]  mhz_now;

	// time stamps still owed by the block, oldest first
	cctc_pkg::cctc_out_t         pending_stamps[$];
	int                          fault_count;
	// random idling on both channels
	bit                          idle_on;

	initial forever #5 clk = ~clk;

	// run limit: well above the slowest legal run
	initial begin
		#15_000_000;
		$display("cycle_count_to_time_converter_tb: done, errors");
		$finish;
	end

	// wrap extension and time split of one snapshot at the current clock
	function automatic cctc_pkg::cctc_out_t convert_snapshot(
		input logic [cctc_pkg::CYC_W-1:0] snap);
		bit [63:0] f, per_s, per_ms, total, sec, rest, ms, us, tick;
		cctc_pkg::cctc_out_t w;
		// strictly below the previous snapshot means the counter wrapped
		if (snap < snap_prev)
			wrap_total = wrap_total + 32'd1;
		snap_prev = snap;
		// a zero clock is taken as 1 MHz
		f      = (mhz_now == '0) ? 64'd1 : 64'(mhz_now);
		per_s  = f * 64'd1_000_000;
		per_ms = f * 64'd1_000;
		total  = {wrap_total, snap};
		sec    = total / per_s;
		rest   = total - sec * per_s;
		ms     = rest / per_ms;
		rest   = rest - ms * per_ms;
		us     = rest / f;
		tick   = sec * 64'd1_000 + ms;
		w.total_cycles = total;
		w.seconds      = sec[cctc_pkg::SEC_W-1:0];
		w.milliseconds = ms[cctc_pkg::FRAC_W-1:0];
		w.microseconds = us[cctc_pkg::FRAC_W-1:0];
		w.ms_tick      = tick[cctc_pkg::TICK_W-1:0];
		w.total_us     = sec * 64'd1_000_000 + ms * 64'd1_000 + us;
		return w;
	endfunction

	// next random snapshot: mostly counter-like runs, with wraps and noise
	function automatic logic [cctc_pkg::CYC_W-1:0] pick_snapshot();
		int unsigned kind;
		kind = $urandom_range(99);
		if (kind < 40)
			return snap_prev + cctc_pkg::CYC_W'($urandom_range(1, 1 << 20));
		else if (kind < 55)
			return snap_prev + cctc_pkg::CYC_W'($urandom);
		else if (kind < 65)
			return snap_prev;
		else if (kind < 75)
			return 32'hFFFF_FFFF - cctc_pkg::CYC_W'($urandom_range(0, 255));
		else if (kind < 85)
			return cctc_pkg::CYC_W'($urandom_range(0, 255));
		else
			return cctc_pkg::CYC_W'($urandom);
	endfunction

	task automatic check_field(input string name, input logic [63:0] want,
		input logic [63:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			fault_count++;
		end
	endtask

	// result side: random stalls, driven on the falling edge
	initial begin
		stamp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			stamp_ch.ready <= !(idle_on && $urandom_range(99) < 25);
		end
	end

	// every taken result word is matched against the oldest owed stamp
	always @(posedge clk) begin : stamp_check
		cctc_pkg::cctc_out_t want;
		if (arst_n && stamp_ch.valid && stamp_ch.ready) begin
			if (pending_stamps.size() == 0) begin
				$error("result word with none owed: total_cycles %0d",
					stamp_ch.data.total_cycles);
				fault_count++;
			end else begin
				want = pending_stamps.pop_front();
				check_field("total_cycles", want.total_cycles,
					stamp_ch.data.total_cycles);
				check_field("seconds", 64'(want.seconds),
					64'(stamp_ch.data.seconds));
				check_field("milliseconds", 64'(want.milliseconds),
					64'(stamp_ch.data.milliseconds));
				check_field("microseconds", 64'(want.microseconds),
					64'(stamp_ch.data.microseconds));
				check_field("ms_tick", 64'(want.ms_tick),
					64'(stamp_ch.data.ms_tick));
				check_field("total_us", want.total_us, stamp_ch.data.total_us);
			end
		end
	end

	// offer one snapshot word, optionally after a random gap, and wait for it to be taken
	task automatic send_snapshot(input logic [cctc_pkg::CYC_W-1:0] snap);
		@(negedge clk);
		while (idle_on && $urandom_range(99) < 25) begin
			sample_ch.valid <= 1'b0;
			@(negedge clk);
		end
		sample_ch.valid            <= 1'b1;
		sample_ch.data.cycle_count <= snap;
		do @(posedge clk); while (!sample_ch.ready);
		pending_stamps.push_back(convert_snapshot(snap));
	endtask

	// stop offering and let every owed stamp come back; leaves the block idle
	task automatic wait_for_stamps();
		@(negedge clk);
		sample_ch.valid <= 1'b0;
		while (pending_stamps.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// clock register is only touched with no word in flight
	task automatic write_mhz(input logic [cctc_pkg::MHZ_W-1:0] mhz);
		wait_for_stamps();
		cfg_we    <= 1'b1;
		cfg_wdata <= mhz;
		@(negedge clk);
		cfg_we    <= 1'b0;
		mhz_now   = mhz;
	endtask

	// reset clock of 170 MHz: first snapshot, second and millisecond edges, wraps, repeats
	task automatic test_reset_defaults();
		send_snapshot(32'd0);
		send_snapshot(32'd169);
		send_snapshot(32'd169_999);
		send_snapshot(32'd170_000);
		send_snapshot(32'd169_999_999);
		send_snapshot(32'd170_000_000);
		send_snapshot(32'hFFFF_FFFF);
		send_snapshot(32'd0);
		send_snapshot(32'd0);
		send_snapshot(32'hFFFF_FFFF);
	endtask

	// zero clock, slowest and fastest in range, and above range
	task automatic test_clock_extremes();
		logic [cctc_pkg::MHZ_W-1:0] setting[4];
		setting = '{10'd0, 10'd1, 10'd1000, 10'd1023};
		foreach (setting[i]) begin
			write_mhz(setting[i]);
			send_snapshot(32'd999_999);
			send_snapshot(32'd1_000_000);
			send_snapshot(32'd1);
		end
	endtask

	// several clock settings, each with a long random run of snapshots
	task automatic test_random_traffic();
		logic [cctc_pkg::MHZ_W-1:0] mhz;
		for (int phase = 0; phase < 5; phase++) begin
			case ($urandom_range(4))
				0: mhz = 10'd0;
				1: mhz = 10'd1;
				2: mhz = 10'd1000;
				3: mhz = 10'd1023;
				default: mhz = cctc_pkg::MHZ_W'($urandom_range(1, 1000));
			endcase
			write_mhz(mhz);
			repeat (190) send_snapshot(pick_snapshot());
		end
	endtask

	// a long stretch with no idling on either side
	task automatic test_back_to_back();
		write_mhz(cctc_pkg::MHZ_W'($urandom_range(1, 1000)));
		idle_on = 1'b0;
		repeat (200) send_snapshot(pick_snapshot());
		idle_on = 1'b1;
	endtask

	// sender holds off mid-run until every owed stamp is back
	task automatic test_drain_pause();
		repeat (60) send_snapshot(pick_snapshot());
		wait_for_stamps();
		repeat (60) send_snapshot(pick_snapshot());
	endtask

	initial begin
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_wdata      = '0;
		sample_ch.valid = 1'b0;
		sample_ch.data  = '0;
		idle_on        = 1'b1;
		fault_count    = 0;
		snap_prev      = '0;
		wrap_total     = '0;
		mhz_now        = cctc_pkg::MHZ_RESET;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_clock_extremes();
		test_random_traffic();
		test_back_to_back();
		test_drain_pause();

		// drain and give the block a full conversion time to show any stray word
		wait_for_stamps();
		repeat (100) @(negedge clk);
		if (fault_count == 0)
			$display("cycle_count_to_time_converter_tb: done, clean");
		else
			$display("cycle_count_to_time_converter_tb: done, errors");
		$finish;
	end

endmodule
